>>> hdl/dltq_pkg.sv
// Package for the delta-list timer queue.
// Holds the beat payload types, action and result codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package dltq_pkg;

  // Largest delta a slot may carry.
  localparam logic [31:0] DELTA_MAX = 32'hFFFF_FFFE;

  // Action codes of a command beat.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_FIRED    = 3'd0;
  localparam logic [2:0] KIND_STARTED  = 3'd1;
  localparam logic [2:0] KIND_STOPPED  = 3'd2;
  localparam logic [2:0] KIND_INACTIVE = 3'd3;
  localparam logic [2:0] KIND_IDLE     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] timeout_ticks;
    logic        periodic;
  } cmd_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [3:0] slot_id;
    logic       last;
  } result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_R_CHK,
    S_R_ADD,
    S_I_START,
    S_I_CHK,
    S_I_FIN,
    S_I_LINK,
    S_T_DEC,
    S_T_NEXT,
    S_T_CHK
  } state_t;

endpackage

>>> hdl/dltq_out_stage.sv
// Output register of the timer queue: holds one result beat until it is taken.
// Depends on dltq_pkg for the result type.
`timescale 1ns / 1ps

module dltq_out_stage
  import dltq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_item,
  output logic    free,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  // The stage can take a new beat when empty or when its beat leaves now.
  assign free = !res_valid || res_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load && free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load && free) begin
      res <= load_item;
    end
  end

endmodule

>>> hdl/delta_list_timer_queue_unit.sv
// Delta-list timer queue: a sequencer walks the linked slot list one slot per cycle.
// Start: one compare per listed slot passed, then a step that links the slot behind its
// predecessor; a start of a listed slot first removes it and restarts the walk. Stop: one visit
// per slot up to the target and a step that merges its delta forward. Tick: on a non-empty list
// the head delta is decremented, each slot that fires is unlinked and each periodic one is walked back in.
// One item at a time; a full output register adds stalls. Reset empties the list.
`timescale 1ns / 1ps

module delta_list_timer_queue_unit
  import dltq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int PW = $clog2(TIMER_SLOTS + 1);
  localparam int IW = $clog2(TIMER_SLOTS);
  localparam logic [PW-1:0] SENT = PW'(TIMER_SLOTS);

  // Sequencer and list registers.
  state_t state, state_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] cur, cur_next;
  logic [PW-1:0] prev, prev_next;
  logic [IW-1:0] op_slot, op_slot_next;
  logic [31:0] op_d, op_d_next;
  logic [31:0] carry, carry_next;
  logic op_start, op_start_next;
  logic [IW-1:0] fired, fired_next;
  logic [2:0] em_kind, em_kind_next;
  logic [3:0] em_slot, em_slot_next;
  logic [TIMER_SLOTS-1:0] active, active_next;

  // Slot memories with one registered read port shared by all fields.
  logic [PW-1:0] next_mem [TIMER_SLOTS];
  logic [31:0] delta_mem [TIMER_SLOTS];
  logic [31:0] reload_mem [TIMER_SLOTS];
  logic per_mem [TIMER_SLOTS];
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] next_q;
  logic [31:0] delta_q, reload_q;
  logic per_q;

  logic next_we, delta_we, cfg_we;
  logic [IW-1:0] next_wa, delta_wa, cfg_wa;
  logic [PW-1:0] next_wd;
  logic [31:0] delta_wd, reload_wd;
  logic per_wd;

  // Output stage connection.
  logic push, out_free;
  result_t push_item;

  // Decoded command and shared conditions.
  logic accept, id_ok, id_active, head_end, nq_end, hit, ins_lt, nd_zero, do_fire;
  logic [IW-1:0] id_idx, head_idx, nq_idx, cur_idx, prev_idx;
  logic [31:0] timeout_r, start_d, dec_d;
  logic [32:0] add_sum;
  logic [31:0] add_sat;

  assign cmd_ready = (state == S_IDLE);
  assign accept = cmd_valid && cmd_ready;
  assign id_ok = (32'(cmd.timer_id) < TIMER_SLOTS);
  assign id_idx = IW'(cmd.timer_id);
  assign id_active = id_ok && active[id_idx];
  assign head_end = (head == SENT);
  assign nq_end = (next_q == SENT);
  assign head_idx = head_end ? '0 : head[IW-1:0];
  assign nq_idx = nq_end ? '0 : next_q[IW-1:0];
  assign cur_idx = cur[IW-1:0];
  assign prev_idx = prev[IW-1:0];
  assign hit = (cur == PW'(op_slot));
  assign ins_lt = (delta_q < op_d);
  assign nd_zero = (delta_q <= 32'd1);
  assign dec_d = (delta_q != 32'd0) ? delta_q - 32'd1 : 32'd0;

  // Timeout clamped to one..DELTA_MAX, and the start delta one above it, at most DELTA_MAX.
  assign timeout_r = (cmd.timeout_ticks == 32'd0) ? 32'd1 :
                     ((cmd.timeout_ticks > DELTA_MAX) ? DELTA_MAX : cmd.timeout_ticks);
  assign start_d = (timeout_r < DELTA_MAX) ? timeout_r + 32'd1 : DELTA_MAX;

  // Saturating merge of a removed slot's delta into its successor.
  assign add_sum = {1'b0, delta_q} + {1'b0, carry};
  assign add_sat = (add_sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : add_sum[31:0];

  // The head fires when its delta reaches zero at the tick or on a later check.
  assign do_fire = ((state == S_T_DEC) && nd_zero) ||
                   ((state == S_T_CHK) && out_free && (delta_q == 32'd0));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (cmd.action)
            ACT_TICK:  state_next = head_end ? S_EMIT : S_T_DEC;
            ACT_START: begin
              if (!id_ok) state_next = S_EMIT;
              else if (id_active) state_next = S_R_CHK;
              else if (head_end) state_next = S_I_FIN;
              else state_next = S_I_CHK;
            end
            ACT_STOP:  state_next = id_active ? S_R_CHK : S_EMIT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_R_CHK: begin
        if (hit) begin
          if (!nq_end) state_next = S_R_ADD;
          else state_next = op_start ? S_I_START : S_EMIT;
        end
      end
      S_R_ADD:   state_next = op_start ? S_I_START : S_EMIT;
      S_I_START: state_next = head_end ? S_I_FIN : S_I_CHK;
      S_I_CHK: begin
        if (!ins_lt || nq_end) state_next = S_I_FIN;
      end
      S_I_FIN: begin
        if (prev != SENT) state_next = S_I_LINK;
        else state_next = op_start ? S_EMIT : S_T_NEXT;
      end
      S_I_LINK:  state_next = op_start ? S_EMIT : S_T_NEXT;
      S_T_DEC: begin
        if (nd_zero) state_next = per_q ? S_I_START : S_T_NEXT;
        else state_next = S_EMIT;
      end
      S_T_NEXT:  state_next = head_end ? S_EMIT : S_T_CHK;
      S_T_CHK: begin
        if (out_free) begin
          if (delta_q == 32'd0) state_next = per_q ? S_I_START : S_T_NEXT;
          else state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result pushes.
  always_comb begin
    head_next = head;
    cur_next = cur;
    prev_next = prev;
    op_slot_next = op_slot;
    op_d_next = op_d;
    carry_next = carry;
    op_start_next = op_start;
    fired_next = fired;
    em_kind_next = em_kind;
    em_slot_next = em_slot;
    active_next = active;
    rd_addr = head_idx;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    delta_we = 1'b0;
    delta_wa = '0;
    delta_wd = '0;
    cfg_we = 1'b0;
    cfg_wa = id_idx;
    reload_wd = timeout_r;
    per_wd = cmd.periodic;
    push = 1'b0;
    push_item = '{result_kind: em_kind, slot_id: em_slot, last: 1'b1};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_slot_next = id_idx;
          op_start_next = (cmd.action == ACT_START);
          prev_next = SENT;
          cur_next = head;
          em_slot_next = cmd.timer_id;
          priority case (cmd.action)
            ACT_TICK: begin
              em_kind_next = KIND_IDLE;
              em_slot_next = '0;
            end
            ACT_START: begin
              if (!id_ok) begin
                em_kind_next = KIND_INACTIVE;
              end else begin
                cfg_we = 1'b1;
                op_d_next = start_d;
                em_kind_next = KIND_STARTED;
              end
            end
            ACT_STOP: begin
              if (id_active) begin
                em_kind_next = KIND_STOPPED;
              end else begin
                em_kind_next = KIND_INACTIVE;
                if (id_ok) active_next[id_idx] = 1'b0;
              end
            end
            default: begin
              em_kind_next = em_kind;
            end
          endcase
        end
      end

      // Removal walk: one listed slot per cycle until the target is met.
      S_R_CHK: begin
        if (hit) begin
          if (prev == SENT) begin
            head_next = next_q;
          end else begin
            next_we = 1'b1;
            next_wa = prev_idx;
            next_wd = next_q;
          end
          if (!nq_end) begin
            rd_addr = nq_idx;
            cur_next = next_q;
            carry_next = delta_q;
          end else if (!op_start) begin
            active_next[op_slot] = 1'b0;
          end
        end else begin
          prev_next = cur;
          cur_next = next_q;
          rd_addr = nq_idx;
        end
      end

      S_R_ADD: begin
        delta_we = 1'b1;
        delta_wa = cur_idx;
        delta_wd = add_sat;
        if (!op_start) active_next[op_slot] = 1'b0;
      end

      S_I_START: begin
        prev_next = SENT;
        cur_next = head;
      end

      // Insertion walk: subtract deltas while the slot belongs further down.
      S_I_CHK: begin
        if (ins_lt) begin
          op_d_next = op_d - delta_q;
          prev_next = cur;
          cur_next = next_q;
          rd_addr = nq_idx;
        end else begin
          delta_we = 1'b1;
          delta_wa = cur_idx;
          delta_wd = delta_q - op_d;
        end
      end

      S_I_FIN: begin
        delta_we = 1'b1;
        delta_wa = op_slot;
        delta_wd = op_d;
        next_we = 1'b1;
        next_wa = op_slot;
        next_wd = cur;
        active_next[op_slot] = 1'b1;
        if (prev == SENT) head_next = PW'(op_slot);
      end

      S_I_LINK: begin
        next_we = 1'b1;
        next_wa = prev_idx;
        next_wd = PW'(op_slot);
      end

      S_T_DEC: begin
        delta_we = 1'b1;
        delta_wa = head_idx;
        delta_wd = dec_d;
        if (!nd_zero) begin
          em_kind_next = KIND_IDLE;
          em_slot_next = '0;
        end
      end

      S_T_NEXT: begin
        if (head_end) begin
          em_kind_next = KIND_FIRED;
          em_slot_next = 4'(fired);
        end
      end

      // The previous firing is sent once it is known whether another follows.
      S_T_CHK: begin
        push = out_free;
        push_item = '{result_kind: KIND_FIRED, slot_id: 4'(fired),
                      last: (delta_q != 32'd0)};
      end

      S_EMIT: begin
        push = out_free;
      end

      default: begin
        push = 1'b0;
      end
    endcase

    // Firing the head: unlink it, then reload it or retire it.
    if (do_fire) begin
      fired_next = head_idx;
      head_next = next_q;
      if (per_q) begin
        op_slot_next = head_idx;
        op_d_next = reload_q;
        op_start_next = 1'b0;
      end else begin
        active_next[head_idx] = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= SENT;
      active <= '0;
    end else begin
      state <= state_next;
      head <= head_next;
      active <= active_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    prev <= prev_next;
    op_slot <= op_slot_next;
    op_d <= op_d_next;
    carry <= carry_next;
    op_start <= op_start_next;
    fired <= fired_next;
    em_kind <= em_kind_next;
    em_slot <= em_slot_next;
  end

  // Slot memory writes.
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (delta_we) delta_mem[delta_wa] <= delta_wd;
    if (cfg_we) begin
      reload_mem[cfg_wa] <= reload_wd;
      per_mem[cfg_wa] <= per_wd;
    end
  end

  // Registered read of all slot fields at one address.
  always_ff @(posedge clk) begin
    next_q <= next_mem[rd_addr];
    delta_q <= delta_mem[rd_addr];
    reload_q <= reload_mem[rd_addr];
    per_q <= per_mem[rd_addr];
  end

  dltq_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (push),
    .load_item (push_item),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> sim/tb_delta_list_timer_queue_unit.sv
// Testbench for the delta-list timer queue unit: directed, full-list and random command traffic.
// A shadow copy of the timer list predicts each result beat, which is checked in arrival order.
// Depends on dltq_pkg (hdl/dltq_pkg.sv) and delta_list_timer_queue_unit.
`timescale 1ns / 1ps

module tb_delta_list_timer_queue_unit;
  import dltq_pkg::*;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    cmd_ready;
  cmd_t    cmd = '0;
  logic    res_valid;
  logic    res_ready = 1'b0;
  result_t res;

  delta_list_timer_queue_unit #(
    .TIMER_SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer list, updated as each command beat is accepted.
  int unsigned shadow_head = SLOTS;
  int unsigned shadow_next[SLOTS];
  logic [31:0] shadow_delta[SLOTS];
  logic [31:0] shadow_reload[SLOTS];
  bit          shadow_periodic[SLOTS];
  bit          shadow_active[SLOTS];
  result_t     due_results[$];

  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_hold = 0;
  result_t     want;

  // Links a slot into the list so that its expiry lies the given ticks from now.
  function automatic void list_link(int unsigned s, logic [31:0] ticks);
    int unsigned prev;
    int unsigned cur;
    int unsigned n;
    logic [31:0] rest;
    prev = SLOTS;
    cur  = shadow_head;
    n    = 0;
    rest = ticks;
    while (cur < SLOTS && n < SLOTS && shadow_delta[cur] < rest) begin
      rest -= shadow_delta[cur];
      prev  = cur;
      cur   = shadow_next[cur];
      n++;
    end
    if (cur < SLOTS) begin
      if (shadow_delta[cur] >= rest) shadow_delta[cur] -= rest;
      else shadow_delta[cur] = '0;
    end else begin
      cur = SLOTS;
    end
    shadow_delta[s] = rest;
    shadow_next[s]  = cur;
    if (prev < SLOTS) shadow_next[prev] = s;
    else shadow_head = s;
  endfunction

  // Unlinks a slot and hands its delta on to its successor, saturating at DELTA_MAX.
  function automatic bit list_unlink(int unsigned s);
    int unsigned prev;
    int unsigned cur;
    int unsigned nx;
    int unsigned n;
    logic [32:0] sum;
    prev = SLOTS;
    cur  = shadow_head;
    n    = 0;
    while (cur < SLOTS && n < SLOTS) begin
      if (cur == s) begin
        nx = shadow_next[cur];
        if (nx >= SLOTS) nx = SLOTS;
        if (prev < SLOTS) shadow_next[prev] = nx;
        else shadow_head = nx;
        if (nx < SLOTS) begin
          sum = {1'b0, shadow_delta[nx]} + {1'b0, shadow_delta[cur]};
          shadow_delta[nx] = (sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : sum[31:0];
        end
        return 1'b1;
      end
      prev = cur;
      cur  = shadow_next[cur];
      n++;
    end
    return 1'b0;
  endfunction

  function automatic void add_result(logic [2:0] kind, logic [3:0] slot);
    result_t r;
    r.result_kind = kind;
    r.slot_id     = slot;
    r.last        = 1'b0;
    due_results.push_back(r);
  endfunction

  // Works out the result beats caused by one accepted command and queues them.
  function automatic void predict_command(cmd_t c);
    int unsigned s;
    int unsigned n;
    int unsigned id;
    logic [31:0] r;
    logic [31:0] d;
    bit          fired;
    result_t     tail;
    id = 32'(c.timer_id);
    case (c.action)
      ACT_TICK: begin
        fired = 1'b0;
        if (shadow_head < SLOTS) begin
          n = 0;
          if (shadow_delta[shadow_head] != 0) shadow_delta[shadow_head]--;
          while (shadow_head < SLOTS && n < SLOTS && shadow_delta[shadow_head] == 0) begin
            s = shadow_head;
            shadow_head = (shadow_next[s] < SLOTS) ? shadow_next[s] : SLOTS;
            add_result(KIND_FIRED, s[3:0]);
            fired = 1'b1;
            if (shadow_periodic[s]) begin
              r = shadow_reload[s];
              if (r == 0) r = 32'd1;
              if (r > DELTA_MAX) r = DELTA_MAX;
              list_link(s, r);
            end else begin
              shadow_active[s] = 1'b0;
            end
            n++;
          end
        end
        if (!fired) add_result(KIND_IDLE, 4'd0);
      end
      ACT_START: begin
        // A four-bit slot index is always in range with sixteen slots.
        r = (c.timeout_ticks == 0) ? 32'd1 : c.timeout_ticks;
        if (r > DELTA_MAX) r = DELTA_MAX;
        d = (r < DELTA_MAX) ? r + 32'd1 : DELTA_MAX;
        if (shadow_active[id]) void'(list_unlink(id));
        shadow_reload[id]   = r;
        shadow_periodic[id] = c.periodic;
        list_link(id, d);
        shadow_active[id] = 1'b1;
        add_result(KIND_STARTED, c.timer_id);
      end
      ACT_STOP: begin
        if (shadow_active[id] && list_unlink(id)) begin
          shadow_active[id] = 1'b0;
          add_result(KIND_STOPPED, c.timer_id);
        end else begin
          shadow_active[id] = 1'b0;
          add_result(KIND_INACTIVE, c.timer_id);
        end
      end
      default: return;
    endcase
    tail = due_results.pop_back();
    tail.last = 1'b1;
    due_results.push_back(tail);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  // Sends one command beat; the sender runs in bursts with random gaps between them.
  task automatic send_cmd(logic [1:0] action, logic [3:0] id, logic [31:0] timeout, bit per);
    int unsigned gap;
    logic [63:0] junk;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        cmd_valid = 1'b0;
        junk = {$urandom, $urandom};
        cmd = junk[$bits(cmd_t)-1:0];
      end
    end
    @(negedge clk);
    cmd_valid        = 1'b1;
    cmd.action        = action;
    cmd.timer_id      = id;
    cmd.timeout_ticks = timeout;
    cmd.periodic      = per;
    do @(posedge clk); while (!cmd_ready);
    predict_command(cmd);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_timeout();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 6);
    if (roll < 85) return $urandom_range(7, 40);
    if (roll < 95) return $urandom;
    case ($urandom_range(0, 2))
      0: return 32'hFFFF_FFFD;
      1: return 32'hFFFF_FFFC;
      default: return 32'd0;
    endcase
  endfunction

  // Extremes of the fields, every action and the special cases of the list.
  task automatic test_directed_cases();
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);             // tick on an empty list
    send_cmd(ACT_STOP, 4'd3, 32'd0, 1'b0);             // stop of an inactive slot
    send_cmd(ACT_START, 4'd0, 32'd0, 1'b0);            // zero timeout is taken as one
    send_cmd(ACT_TICK, 4'd7, 32'hFFFF_FFFF, 1'b1);
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);             // slot 0 fires, one-shot
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_cmd(ACT_START, 4'd15, 32'd1, 1'b1);
    send_cmd(ACT_START, 4'd10, 32'hFFFF_FFFF, 1'b0);   // timeout saturates
    send_cmd(ACT_START, 4'd5, 32'hFFFF_FFFD, 1'b1);    // timeout one below DELTA_MAX
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);             // periodic slot 15 fires and reloads
    send_cmd(ACT_START, 4'd15, 32'd3, 1'b0);           // restart of an active slot
    send_cmd(ACT_STOP, 4'd5, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 4'd5, 32'd0, 1'b0);
    send_cmd(ACT_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1);   // unused action, no result
    send_cmd(ACT_START, 4'd6, 32'd2, 1'b0);            // three slots with equal expiry
    send_cmd(ACT_START, 4'd9, 32'd2, 1'b1);
    send_cmd(ACT_START, 4'd12, 32'd2, 1'b0);
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 4'd9, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 4'd10, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 4'd15, 32'd0, 1'b0);
  endtask

  // Every slot periodic with the same timeout, so that single ticks fire the whole list.
  task automatic test_full_list_fire();
    for (int i = 0; i < SLOTS; i++) send_cmd(ACT_START, i[3:0], 32'd1, 1'b1);
    repeat (4) send_cmd(ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
    for (int i = SLOTS - 1; i >= 0; i--) send_cmd(ACT_STOP, i[3:0], $urandom, 1'($urandom));
  endtask

  // Random starts, stops and ticks with mostly short timeouts so that timers fire often.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned roll;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 42) begin
        send_cmd(ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
        sent++;
      end else if (roll < 77) begin
        send_cmd(ACT_START, 4'($urandom), pick_timeout(), 1'($urandom));
        sent++;
      end else if (roll < 96) begin
        send_cmd(ACT_STOP, 4'($urandom), $urandom, 1'($urandom));
        sent++;
      end else begin
        send_cmd(ACT_UNUSED, 4'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  // Result receiver: stalls in four patterns in turn: always ready, random, random runs, alternating.
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 160) % 4)
      0: res_ready = 1'b1;
      1: res_ready = 1'($urandom_range(0, 1));
      2: begin
        if (rx_hold == 0) begin
          res_ready = !res_ready;
          rx_hold = res_ready ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end else begin
          rx_hold--;
        end
      end
      default: res_ready = rx_cycle[1];
    endcase
  end

  // Each result beat is checked against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat kind %0d slot %0d last %0b",
                                res.result_kind, res.slot_id, res.last));
      end else begin
        want = due_results.pop_front();
        if (res.result_kind !== want.result_kind || res.slot_id !== want.slot_id ||
            res.last !== want.last)
          note_mismatch($sformatf("expected kind %0d slot %0d last %0b, got %0d %0d %0b",
                                  want.result_kind, want.slot_id, want.last,
                                  res.result_kind, res.slot_id, res.last));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_full_list_fire();
    test_random_traffic();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
